FILE: rtl/wsa_pkg.sv
package wsa_pkg;

  // Table geometry
  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned WEIGHT_BITS = 32;
  localparam int unsigned IDX_W       = $clog2(SLOTS);
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1);

  // Fixed field widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ID_W  = 11;
  localparam int unsigned WGT_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned SUM_W = 42;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((ID_W + WGT_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ID_W + SUM_W + ID_W + 7) / 8) * 8;

  // Weight memory entry: live flag on top of the weight
  localparam int unsigned WMEM_W = WEIGHT_BITS + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_RESET   = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

endpackage

FILE: rtl/wsa_ram.sv
module wsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/weighted_slot_allocator.sv
// Channel  Dir  Handshake                    tuser   tdata (low bit up)
// s_axis   in   s_axis_tvalid/s_axis_tready  action  slot_id, weight, zero pad
// m_axis   out  m_axis_tvalid/m_axis_tready  status  assigned_slot, total_weight, live_count
//
// For each item, the accept cycle reads the weight memory (or the
// free-id memory for add), and the commit cycle writes back and loads the result.
// Reset clears only the control registers; the memories need no clearing pass.
// A full output register holds the write-back cycle until the result is taken;
// the input is taken again once the item has been written back.
module weighted_slot_allocator
  import wsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ACT_W-1:0]      s_axis_tuser,   // action
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // slot_id, weight, pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ST_W-1:0]       m_axis_tuser,   // status
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // assigned_slot, total_weight, live_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Table control registers
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] qcount_q, qcount_d;
  logic [CNT_W-1:0] high_water_q, high_water_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  // Item captured at accept
  action_e          act_q;
  logic [ID_W-1:0]  slot_id_q;
  logic [WEIGHT_BITS-1:0] wgt_q;
  logic [SUM_W-1:0] sum_plus_w_q;
  logic             in_range_q;
  logic             use_queue_q;
  logic             full_q;
  logic [CNT_W-1:0] new_id_q;

  // Output register
  logic             out_valid_q;
  logic [ID_W-1:0]  out_slot_q;
  status_e          out_status_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [CNT_W-1:0] out_occ_q;

  // Input decode
  action_e                act_in;
  logic [ID_W-1:0]        slot_id_in;
  logic [WEIGHT_BITS-1:0] wgt_in;
  logic                   accept;
  logic                   in_range_in;
  logic [IDX_W-1:0]       slot_idx_in;

  // Memory ports
  logic              wmem_we, wmem_re;
  logic [IDX_W-1:0]  wmem_waddr;
  logic [WMEM_W-1:0] wmem_wdata, wmem_rdata;
  logic              qmem_we, qmem_re;
  logic [IDX_W-1:0]  qmem_waddr;
  logic [IDX_W-1:0]  qmem_rdata;

  // Commit cycle
  logic             commit;
  logic             live;
  logic [WEIGHT_BITS-1:0] old_w;
  logic [CNT_W-1:0] add_id;
  logic [IDX_W-1:0] add_idx;
  logic [IDX_W-1:0] slot_idx_q;
  logic [ID_W-1:0]  res_slot;
  status_e          res_status;

  assign act_in      = action_e'(s_axis_tuser);
  assign slot_id_in  = s_axis_tdata[ID_W-1:0];
  assign wgt_in      = s_axis_tdata[ID_W +: WEIGHT_BITS];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign in_range_in = (slot_id_in != '0) && (CNT_W'(slot_id_in) <= high_water_q);
  assign slot_idx_in = IDX_W'(slot_id_in - ID_W'(1));

  // Weight memory: read at accept, write back at commit
  assign wmem_re = accept && ((act_in == ACT_CLEAR) || (act_in == ACT_REPLACE));
  // Free-id memory: read the head at accept for add, popped at commit
  assign qmem_re = accept && (act_in == ACT_ADD) && (qcount_q != '0);

  wsa_ram #(
    .WIDTH(WMEM_W),
    .DEPTH(SLOTS)
  ) u_wmem (
    .clk_i  (clk_i),
    .we_i   (wmem_we),
    .waddr_i(wmem_waddr),
    .wdata_i(wmem_wdata),
    .re_i   (wmem_re),
    .raddr_i(slot_idx_in),
    .rdata_o(wmem_rdata)
  );

  wsa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOTS)
  ) u_qmem (
    .clk_i  (clk_i),
    .we_i   (qmem_we),
    .waddr_i(qmem_waddr),
    .wdata_i(slot_idx_q),
    .re_i   (qmem_re),
    .raddr_i(head_q),
    .rdata_o(qmem_rdata)
  );

  assign commit     = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign slot_idx_q = IDX_W'(slot_id_q - ID_W'(1));
  assign live       = in_range_q && wmem_rdata[WEIGHT_BITS];
  assign old_w      = wmem_rdata[WEIGHT_BITS-1:0];
  assign add_id     = use_queue_q ? (CNT_W'(qmem_rdata) + CNT_W'(1)) : new_id_q;
  assign add_idx    = IDX_W'(add_id - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    qcount_d     = qcount_q;
    high_water_d = high_water_q;
    occ_d        = occ_q;
    sum_d        = sum_q;
    wmem_we      = 1'b0;
    wmem_waddr   = slot_idx_q;
    wmem_wdata   = {1'b1, wgt_q};
    qmem_we      = 1'b0;
    qmem_waddr   = tail_q;
    res_slot     = slot_id_q;
    res_status   = ST_OK;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (commit) begin
      state_d = S_IDLE;
      unique case (act_q)
        ACT_ADD: begin
          if (full_q) begin
            res_slot   = '0;
            res_status = ST_FULL;
          end else begin
            wmem_we    = 1'b1;
            wmem_waddr = add_idx;
            sum_d      = sum_plus_w_q;
            occ_d      = occ_q + CNT_W'(1);
            res_slot   = ID_W'(add_id);
            if (use_queue_q) begin
              head_d   = (head_q == IDX_W'(SLOTS - 1)) ? '0 : head_q + IDX_W'(1);
              qcount_d = qcount_q - CNT_W'(1);
            end else begin
              high_water_d = new_id_q;
            end
          end
        end
        ACT_CLEAR, ACT_REPLACE: begin
          if (!live) begin
            res_slot   = '0;
            res_status = ST_BAD_ID;
          end else if (act_q == ACT_CLEAR) begin
            // drop the weight, mark dead, push the id onto the free list
            sum_d      = sum_q - SUM_W'(old_w);
            wmem_we    = 1'b1;
            wmem_wdata = '0;
            qmem_we    = 1'b1;
            tail_d     = (tail_q == IDX_W'(SLOTS - 1)) ? '0 : tail_q + IDX_W'(1);
            qcount_d   = qcount_q + CNT_W'(1);
            occ_d      = occ_q - CNT_W'(1);
          end else begin
            sum_d   = sum_plus_w_q - SUM_W'(old_w);
            wmem_we = 1'b1;
          end
        end
        ACT_RESET: begin
          head_d       = '0;
          tail_d       = '0;
          qcount_d     = '0;
          high_water_d = '0;
          occ_d        = '0;
          sum_d        = '0;
        end
        default: begin
          res_slot = slot_id_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      qcount_q     <= '0;
      high_water_q <= '0;
      occ_q        <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      qcount_q     <= qcount_d;
      high_water_q <= high_water_d;
      occ_q        <= occ_d;
      sum_q        <= sum_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and the pre-added total at accept, and the result at commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q        <= act_in;
      slot_id_q    <= slot_id_in;
      wgt_q        <= wgt_in;
      sum_plus_w_q <= sum_q + SUM_W'(wgt_in);
      in_range_q   <= in_range_in;
      use_queue_q  <= (qcount_q != '0);
      full_q       <= (qcount_q == '0) && (high_water_q == CNT_W'(SLOTS));
      new_id_q     <= high_water_q + CNT_W'(1);
    end
    if (commit) begin
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
      out_sum_q    <= sum_d;
      out_occ_q    <= occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({ID_W'(out_occ_q), out_sum_q, out_slot_q});

endmodule
